// ===== design/ukrt_pkg.sv =====
// Package: shared constants, types and codes of the key range table lookup block.
package ukrt_pkg;

  // Slot store depth; the address and count widths follow from it.
  localparam int SLOT_DEPTH = 1024;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int CNT_W      = ($clog2(SLOT_DEPTH + 1) > 11) ? $clog2(SLOT_DEPTH + 1) : 11;

  // Field widths.
  localparam int OP_W      = 1;
  localparam int IDX_W     = 10;
  localparam int KEY_W     = 32;
  localparam int RCOUNT_W  = 16;
  localparam int ROFS_W    = 16;
  localparam int ENTRY_W   = 16;
  localparam int MODE_W    = 2;
  localparam int SCOUNT_W  = 11;
  localparam int MAXKEY_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

  // Table modes.
  localparam logic [MODE_W-1:0] MODE_EMPTY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEYS   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RANGES = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY    = 2'd2;

  // One slot as stored in memory.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [RCOUNT_W-1:0] count;
    logic [ROFS_W-1:0]   offset;
  } slot_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

// ===== design/ukrt_if.sv =====
// Interfaces: input, result and configuration channels of the lookup block.
interface ukrt_in_if;
  import ukrt_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_W-1:0]    slot_index;
  logic [KEY_W-1:0]    key;
  logic [RCOUNT_W-1:0] range_count;
  logic [ROFS_W-1:0]   range_offset;
  modport source (output valid, op, slot_index, key, range_count, range_offset, input ready);
  modport sink (input valid, op, slot_index, key, range_count, range_offset, output ready);
endinterface

interface ukrt_out_if;
  import ukrt_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [ENTRY_W-1:0] entry_index;
  modport source (output valid, found, entry_index, input ready);
  modport sink (input valid, found, entry_index, output ready);
endinterface

interface ukrt_cfg_if;
  import ukrt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/uint_key_range_table_lookup.sv =====
// Top level: key to entry index lookup over a slot table, binary search by a shared comparator.
//
//   channel  dir  payload                                          transaction
//   in_ch    in   op, slot_index, key, range_count, range_offset   valid & ready
//   out_ch   out  found, entry_index                               valid & ready
//   cfg_ch   in   index, data (table_mode / slot_count / max_key)  valid & ready
//
// A write transaction loads one slot in the cycle it is taken and gives no result.
// A lookup goes from idle straight to done in empty and direct modes and with no slots in use;
// in key and range modes it first probes, at most floor(log2(slots in use)) + 1 times (11 for
// 1024 slots), one probe per cycle: the slot memory read port and the one key comparator.
// rst_n is synchronous, active low; it clears control and config, not the slot memory.
// The result sits in an output register; a stalled result holds the search in its
// done state, while input stays ready in idle. Config is always ready.
module uint_key_range_table_lookup (
  input  logic clk,
  input  logic rst_n,
  ukrt_in_if.sink    in_ch,
  ukrt_out_if.source out_ch,
  ukrt_cfg_if.sink   cfg_ch
);
  import ukrt_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0]   table_mode_r;
  logic [SCOUNT_W-1:0] slot_count_r;
  logic [MAXKEY_W-1:0] max_key_r;

  // Sequencer and search registers
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    start_r, start_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic                res_found_r, res_found_nxt;
  logic [ENTRY_W-1:0]  res_entry_r, res_entry_nxt;

  // Output register
  logic                out_valid_r;
  logic                out_found_r;
  logic [ENTRY_W-1:0]  out_entry_r;

  // Slot memory
  slot_word_t          slot_mem [SLOT_DEPTH];
  slot_word_t          rd_data_r;
  slot_word_t          wr_data;
  logic [SLOT_AW-1:0]  rd_addr;
  logic [SLOT_AW-1:0]  wr_addr;
  logic                wr_en;

  logic                in_take;
  logic                lookup_take;
  logic                out_load;
  logic                search_mode;
  logic                ranges;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    half;
  logic [CNT_W-1:0]    mid;
  logic                below;
  logic                above;
  logic [KEY_W:0]      range_end;

  // Slots in use, clipped to the store depth
  assign used = (CNT_W'(slot_count_r) > CNT_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH)
                                                            : CNT_W'(slot_count_r);
  assign ranges      = (table_mode_r == MODE_RANGES);
  assign search_mode = (table_mode_r == MODE_KEYS) || ranges;

  assign in_take     = in_ch.valid && in_ch.ready;
  assign lookup_take = in_take && (in_ch.op == OP_LOOKUP);
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Probe of the current window: slot start + n/2. With n == 1 that is the last slot left.
  assign half = n_r >> 1;
  assign mid  = start_r + half;

  // Shared comparator: key against the slot just read. Range end has no wrap.
  assign range_end = {1'b0, rd_data_r.key} + (KEY_W + 1)'(rd_data_r.count);
  assign below     = key_r < rd_data_r.key;
  assign above     = ranges ? ({1'b0, key_r} >= range_end) : (key_r > rd_data_r.key);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (lookup_take) begin
          if (search_mode && (used != '0)) state_nxt = ST_SEARCH;
          else state_nxt = ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (!below && !above) state_nxt = ST_DONE;
        else if (n_nxt == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_SEARCH: in_ch.ready = 1'b0;
      ST_DONE:   in_ch.ready = 1'b0;
      default:   in_ch.ready = 1'b0;
    endcase
  end

  // Search datapath
  always_comb begin
    start_nxt     = start_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_entry_nxt = res_entry_r;
    if (state_r == ST_IDLE) begin
      if (lookup_take) begin
        key_nxt       = in_ch.key;
        start_nxt     = '0;
        n_nxt         = used;
        res_found_nxt = 1'b0;
        res_entry_nxt = '0;
        if ((table_mode_r == MODE_DIRECT) &&
            (in_ch.key <= KEY_W'(max_key_r))) begin
          res_found_nxt = 1'b1;
          res_entry_nxt = in_ch.key[ENTRY_W-1:0];
        end
      end
    end else if (state_r == ST_SEARCH) begin
      if (above) begin
        start_nxt = mid + CNT_W'(1);
        n_nxt     = n_r - half - CNT_W'(1);
      end else if (below) begin
        n_nxt = half;
      end else begin
        res_found_nxt = 1'b1;
        if (ranges) begin
          res_entry_nxt = key_r[ENTRY_W-1:0] - rd_data_r.key[ENTRY_W-1:0] + rd_data_r.offset;
        end else begin
          res_entry_nxt = ENTRY_W'(mid);
        end
      end
    end
  end

  // Next probe address; read data is back for the following cycle.
  assign rd_addr = SLOT_AW'(start_nxt + (n_nxt >> 1));

  assign wr_en   = in_take && (in_ch.op == OP_WRITE) &&
                   (32'(in_ch.slot_index) < 32'(SLOT_DEPTH));
  assign wr_addr = SLOT_AW'(in_ch.slot_index);
  assign wr_data = '{key: in_ch.key, count: in_ch.range_count, offset: in_ch.range_offset};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      table_mode_r <= MODE_EMPTY;
      slot_count_r <= '0;
      max_key_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_TABLE_MODE: table_mode_r <= cfg_ch.data[MODE_W-1:0];
          CFG_SLOT_COUNT: slot_count_r <= cfg_ch.data[SCOUNT_W-1:0];
          CFG_MAX_KEY:    max_key_r    <= cfg_ch.data[MAXKEY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_entry_r <= res_entry_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_entry_r <= res_found_r ? res_entry_r : '0;
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.entry_index = out_entry_r;

`ifndef SYNTH
  // Search window never empty while probing
  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (n_r != '0))
    else $error("search window empty while probing");

  // Search window stays inside the slots in use
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |->
      (({1'b0, start_r} + {1'b0, n_r}) <= {1'b0, used}))
    else $error("search window past slots in use");

  // A miss reports entry zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_entry_r == '0))
    else $error("miss with nonzero entry");

  // A lookup always leaves idle on the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_take |=> (state_r != ST_IDLE))
    else $error("lookup taken but sequencer idle");
`endif

endmodule

// ===== tb/sv/ukrt_lookup_checker.sv =====
// Checker: watches the lookup block's channels, predicts each lookup answer and compares.
module ukrt_lookup_checker (
  input  logic clk,
  input  logic rst_n,
  ukrt_in_if   in_ch,
  ukrt_out_if  out_ch,
  ukrt_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  import ukrt_pkg::*;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] entry;
  } answer_t;

  // Shadow of the block's configuration and slot table.
  logic [MODE_W-1:0]   table_mode;
  logic [SCOUNT_W-1:0] slot_count;
  logic [MAXKEY_W-1:0] max_key;
  logic [KEY_W-1:0]    slot_key [SLOT_DEPTH];
  logic [RCOUNT_W-1:0] slot_span [SLOT_DEPTH];
  logic [ROFS_W-1:0]   slot_ofs [SLOT_DEPTH];

  answer_t answers_due[$];
  int      errors = 0;

  // -1: key below slot s, 1: above, 0: match. Range end is taken without wrap.
  function automatic int probe_slot(logic [SLOT_AW-1:0] s, logic [KEY_W-1:0] key, bit ranges);
    logic [KEY_W:0] lo;
    logic [KEY_W:0] hi;
    lo = {1'b0, slot_key[s]};
    hi = lo + slot_span[s];
    if (!ranges) return (slot_key[s] < key) ? 1 : (slot_key[s] > key) ? -1 : 0;
    if ({1'b0, key} < lo) return -1;
    if ({1'b0, key} >= hi) return 1;
    return 0;
  endfunction

  function automatic answer_t search_table(logic [KEY_W-1:0] key);
    answer_t            ans;
    int                 base;
    int                 span;
    int                 mid;
    int                 last;
    int                 c;
    bit                 ranges;
    bit                 hit;
    logic [SLOT_AW-1:0] hit_slot;
    ans = '0;
    hit = 1'b0;
    case (table_mode) inside
      MODE_DIRECT: begin
        if (key <= {{(KEY_W-MAXKEY_W){1'b0}}, max_key}) begin
          ans.found = 1'b1;
          ans.entry = key[ENTRY_W-1:0];
        end
      end
      MODE_KEYS, MODE_RANGES: begin
        ranges = (table_mode == MODE_RANGES);
        base   = 0;
        span   = (slot_count > SLOT_DEPTH) ? SLOT_DEPTH : int'(slot_count);
        while (span > 1 && !hit) begin
          mid = base + span / 2;
          c   = probe_slot(SLOT_AW'(mid), key, ranges);
          if (c > 0) begin
            last = base + span;
            base = mid + 1;
            span = last - base;
          end else if (c < 0) begin
            span = mid - base;
          end else begin
            hit  = 1'b1;
            base = mid;
          end
        end
        if (!hit && span == 1) hit = (probe_slot(SLOT_AW'(base), key, ranges) == 0);
        if (hit) begin
          hit_slot  = SLOT_AW'(base);
          ans.found = 1'b1;
          // index wraps modulo 2^16
          ans.entry = ranges ? key[ENTRY_W-1:0] - slot_key[hit_slot][ENTRY_W-1:0]
                               + slot_ofs[hit_slot]
                             : ENTRY_W'(base);
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst_n) begin
      table_mode = MODE_EMPTY;
      slot_count = '0;
      max_key    = '0;
      answers_due.delete();
    end else begin
      // results first, so a stray result never pairs with a lookup taken this cycle
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got found=%0b entry_index=%0d",
                   $time, out_ch.found, out_ch.entry_index);
        end else begin
          want = answers_due.pop_front();
          if (out_ch.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_ch.found);
          end
          if (out_ch.entry_index !== want.entry) begin
            errors++;
            $display("%0t: entry_index mismatch, expected %0d, got %0d",
                     $time, want.entry, out_ch.entry_index);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TABLE_MODE: table_mode = cfg_ch.data[MODE_W-1:0];
          CFG_SLOT_COUNT: slot_count = cfg_ch.data[SCOUNT_W-1:0];
          CFG_MAX_KEY:    max_key    = cfg_ch.data[MAXKEY_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_WRITE) begin
          slot_key[in_ch.slot_index]  = in_ch.key;
          slot_span[in_ch.slot_index] = in_ch.range_count;
          slot_ofs[in_ch.slot_index]  = in_ch.range_offset;
        end else begin
          answers_due.push_back(search_table(in_ch.key));
        end
      end
    end
    mismatches  <= errors;
    outstanding <= answers_due.size();
  end

endmodule

// ===== tb/sv/uint_key_range_table_lookup_test.sv =====
// Testbench top: clock, reset, stimulus and verdict for the key range table lookup block.
module uint_key_range_table_lookup_test;
  import ukrt_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 7;
  // settle time covers a lookup of up to 11 probes, with a little margin on top
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_LOOKUPS  = 480;
  localparam int END_WAIT_CYCLES = 5000;
  localparam int LIMIT_CYCLES    = 400000;
  // spare register index; writes to it must leave the block unchanged
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ukrt_in_if  in_ch ();
  ukrt_out_if out_ch ();
  ukrt_cfg_if cfg_ch ();

  int fails;
  int answers_pending;

  // Idle odds per cycle, percent; the main process moves them between regimes.
  int send_idle_pct = 24;
  int recv_idle_pct = 45;
  // Set by the main process to ask the receiver for one long hold-off.
  int hold_cycles   = 0;

  // Stimulus-side copy of the loaded table, used only to aim lookups at hits.
  bit [KEY_W-1:0]    tbl_key [SLOT_DEPTH];
  bit [RCOUNT_W-1:0] tbl_cnt [SLOT_DEPTH];
  int lookups_sent = 0;

  uint_key_range_table_lookup i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ukrt_lookup_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (fails),
    .outstanding (answers_pending)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // One input transaction. Valid stays high after the handshake so that
  // back-to-back items need no extra edge on valid.
  task automatic push_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
                           logic [RCOUNT_W-1:0] cnt, logic [ROFS_W-1:0] ofs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.slot_index   <= idx;
    in_ch.key          <= key;
    in_ch.range_count  <= cnt;
    in_ch.range_offset <= ofs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_slot(logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
                           logic [RCOUNT_W-1:0] cnt, logic [ROFS_W-1:0] ofs);
    tbl_key[idx] = key;
    tbl_cnt[idx] = cnt;
    push_item(OP_WRITE, idx, key, cnt, ofs);
  endtask

  // Lookup with junk in the fields a lookup ignores.
  task automatic lookup(logic [KEY_W-1:0] key);
    lookups_sent++;
    push_item(OP_LOOKUP, IDX_W'($urandom()), key, RCOUNT_W'($urandom()), ROFS_W'($urandom()));
  endtask

  // Sender stops offering until every answer has come back.
  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (answers_pending != 0);
  endtask

  // Registers change only with the block idle. A trailing write could still be
  // in flight after the last answer, hence the settle time.
  task automatic set_config(logic [MODE_W-1:0] mode, logic [SCOUNT_W-1:0] count,
                            logic [MAXKEY_W-1:0] max_k);
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // upper data bits beyond the register width are noise
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_TABLE_MODE;
    cfg_ch.data  <= {(CFG_DAT_W-MODE_W)'($urandom()), mode};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_SLOT_COUNT;
    cfg_ch.data  <= {(CFG_DAT_W-SCOUNT_W)'($urandom()), count};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_MAX_KEY;
    cfg_ch.data  <= max_k;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_SPARE;
    cfg_ch.data  <= CFG_DAT_W'($urandom());
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Loads slots 0..n-1. Sorted tables get ascending starts with random gaps;
  // small tables sometimes sit right under 2^32 to hit the top of the key space.
  task automatic build_table(int n, bit shuffled);
    logic [KEY_W:0]      at;
    logic [RCOUNT_W-1:0] span;
    int                  gap_max;
    gap_max = 1 << 20;
    at = (KEY_W+1)'($urandom_range(0, 32'h3FFF_FFFF));
    if (n <= 8 && $urandom_range(0, 3) == 0) begin
      gap_max = 64;
      at = 33'h1_0000_0000 - 33'(n) * 33'h1_0040;
    end
    for (int s = 0; s < n; s++) begin
      span = ($urandom_range(0, 3) == 0) ? RCOUNT_W'($urandom())
                                          : RCOUNT_W'($urandom_range(0, 64));
      load_slot(IDX_W'(s), shuffled ? KEY_W'($urandom()) : at[KEY_W-1:0], span,
                ROFS_W'($urandom()));
      at = at + span + $urandom_range(0, gap_max);
    end
  endtask

  // Mostly keys that hit or sit on an edge, the rest anywhere.
  function automatic logic [KEY_W-1:0] pick_key(logic [MODE_W-1:0] mode, int used,
                                                logic [MAXKEY_W-1:0] max_k);
    logic [KEY_W:0]     k;
    logic [SLOT_AW-1:0] s;
    int                 r;
    r = $urandom_range(0, 99);
    if (mode == MODE_DIRECT) begin
      if (r < 70) return KEY_W'($urandom_range(0, max_k));
      if (r < 85) return {{(KEY_W-MAXKEY_W){1'b0}}, max_k} + 1;
      return $urandom();
    end
    if (used == 0 || r >= 85) return $urandom();
    s = SLOT_AW'($urandom_range(0, used - 1));
    if (r < 15) return tbl_key[s] - 1;
    if (mode == MODE_RANGES) begin
      // up to one past the range end
      k = {1'b0, tbl_key[s]} + $urandom_range(0, tbl_cnt[s]);
      return k[KEY_W-1:0];
    end
    return tbl_key[s];
  endfunction

  initial begin : stimulus
    logic [MODE_W-1:0]   mode;
    logic [SCOUNT_W-1:0] count;
    logic [MAXKEY_W-1:0] max_k;
    int phase;
    int used;
    int n;
    int r;
    int waited;
    bit searching;
    bit held;
    bit paused;

    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_WRITE;
    in_ch.slot_index   <= '0;
    in_ch.key          <= '0;
    in_ch.range_count  <= '0;
    in_ch.range_offset <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_TABLE_MODE;
    cfg_ch.data        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset leaves the table empty: nothing matches
    lookup(32'h0);
    lookup(32'hFFFF_FFFF);

    // direct map, widest and narrowest accepted range
    set_config(MODE_DIRECT, 11'd0, 16'hFFFF);
    lookup(32'h0);
    lookup(32'h0000_FFFF);
    lookup(32'h0001_0000);
    lookup(32'hFFFF_FFFF);
    set_config(MODE_DIRECT, 11'd2047, 16'h0000);
    lookup(32'h0);
    lookup(32'h1);

    // slot 0: empty range; slot 1: offset wraps past 2^16;
    // slot 2: range reaching beyond 2^32 (end computed without wrap); slot 1023: top index
    load_slot(10'd0, 32'h0, 16'h0000, 16'h0000);
    load_slot(10'd1, 32'h10, 16'hFFFF, 16'hFFFF);
    load_slot(10'd2, 32'hFFFF_FFF0, 16'hFFFF, 16'h0001);
    load_slot(10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);

    set_config(MODE_RANGES, 11'd3, MAXKEY_W'($urandom()));
    lookup(32'h0);
    lookup(32'h10);
    lookup(32'h11);
    lookup(32'h1_000E);
    lookup(32'h1_000F);
    lookup(32'hFFFF_FFEF);
    lookup(32'hFFFF_FFFF);

    set_config(MODE_KEYS, 11'd3, MAXKEY_W'($urandom()));
    lookup(32'h10);
    lookup(32'hFFFF_FFF0);
    lookup(32'h5);

    // no slots in use: never a match
    set_config(MODE_RANGES, 11'd0, MAXKEY_W'($urandom()));
    lookup(32'h10);

    // ---- random part: one table and setting per phase ----
    // Phase 4 fills the whole store, phase 5 reuses it with an oversized count.
    lookups_sent = 0;
    phase  = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (lookups_sent < RANDOM_LOOKUPS) begin
      // idle regimes: sender-light, then receiver-light, then none
      if (lookups_sent < RANDOM_LOOKUPS / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 45;
      end else if (lookups_sent < 2 * RANDOM_LOOKUPS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      r = $urandom_range(0, 9);
      mode = (r == 0) ? MODE_EMPTY : (r < 3) ? MODE_DIRECT : (r < 6) ? MODE_KEYS : MODE_RANGES;
      if (phase == 4 || phase == 5) mode = $urandom_range(0, 1) ? MODE_KEYS : MODE_RANGES;
      searching = (mode == MODE_KEYS || mode == MODE_RANGES);

      r = $urandom_range(0, 9);
      if (phase == 4)     count = 11'd1024;
      else if (phase == 5) count = SCOUNT_W'($urandom_range(1025, 2047));
      else if (!searching) count = SCOUNT_W'($urandom());
      else if (r == 0)    count = 11'd0;
      else if (r == 1)    count = SCOUNT_W'($urandom_range(25, 200));
      else                count = SCOUNT_W'($urandom_range(1, 24));
      used = !searching ? 0 : (count > SLOT_DEPTH) ? SLOT_DEPTH : int'(count);

      r = $urandom_range(0, 9);
      max_k = (r < 2) ? 16'h0000 : (r < 4) ? 16'hFFFF : MAXKEY_W'($urandom());

      set_config(mode, count, max_k);
      // only slots in use are ever read, and each is loaded first
      if (searching && phase != 5) build_table(used, phase != 4 && $urandom_range(0, 7) == 0);

      n = $urandom_range(12, 30);
      for (int i = 0; i < n; i++) begin
        // long receiver hold-off while lookups keep coming: input must stall
        if (!held && lookups_sent >= 40) begin
          held = 1'b1;
          hold_cycles = HOLD_CYCLES;
        end
        // sender pause mid-phase until the block has answered everything
        if (!paused && lookups_sent >= RANDOM_LOOKUPS / 2) begin
          paused = 1'b1;
          drain_answers();
        end
        // occasional stray write: may break the sort order of the live table
        if ($urandom_range(0, 19) == 0)
          load_slot(IDX_W'($urandom()), KEY_W'($urandom()), RCOUNT_W'($urandom()),
                    ROFS_W'($urandom()));
        lookup(pick_key(mode, used, max_k));
      end
      phase++;
    end

    // ---- wind down ----
    in_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (answers_pending != 0 && waited < END_WAIT_CYCLES);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0 && answers_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== uint_key_range_table_lookup.f =====
design/ukrt_pkg.sv
design/ukrt_if.sv
design/uint_key_range_table_lookup.sv
tb/sv/ukrt_lookup_checker.sv
tb/sv/uint_key_range_table_lookup_test.sv
